FILE: design/tfc_pkg.sv
// shared types and constants of the temperature fan curve block
// used by tfc_div and temperature_fan_curve, no dependencies
package tfc_pkg;

  localparam int unsigned SENSORS   = 4;
  localparam int unsigned RAW_W     = 12;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned DUTY_W    = 12;
  localparam int unsigned PROD_W    = 28;
  localparam int unsigned DIV_STEPS = 12;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned IN_DATA_W  = SENSORS * RAW_W;
  localparam int unsigned OUT_DATA_W = 2 * DUTY_W + SENSORS * TEMP_W;

  typedef logic [RAW_W-1:0]  raw_t;
  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // full scale of the conversion in centidegrees and adc / duty full codes
  localparam temp_t TEMP_SCALE = 16'd33000;
  localparam duty_t DUTY_MAX   = 12'd4095;
  localparam logic [12:0] ADC_DIV = 13'd4095;

  localparam temp_t START_RESET = 16'd4000;
  localparam temp_t FULL_RESET  = 16'd6000;

  // register map: start thresholds first, then full thresholds
  localparam cfg_idx_t CFG_START_BASE = 3'd0;
  localparam cfg_idx_t CFG_FULL_BASE  = 3'd4;

endpackage

FILE: design/tfc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on tfc_pkg; quotient valid only when num < den * 2**DIV_STEPS
module tfc_div (
  input  logic          clk,
  input  logic          en,
  input  tfc_pkg::prod_t num_i,
  input  tfc_pkg::temp_t den_i,
  output tfc_pkg::duty_t quo_o
);

  localparam int unsigned N = tfc_pkg::DIV_STEPS;

  tfc_pkg::prod_t rem_r [N];
  tfc_pkg::temp_t den_r [N];
  tfc_pkg::duty_t quo_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    tfc_pkg::prod_t rem_in;
    tfc_pkg::temp_t den_in;
    tfc_pkg::duty_t quo_in;
    tfc_pkg::prod_t shifted;
    logic           take;
    tfc_pkg::prod_t rem_nxt;
    tfc_pkg::duty_t quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // trial subtract of the divisor aligned to quotient bit N-1-k
    assign shifted = tfc_pkg::prod_t'(den_in) << (N - 1 - k);
    assign take    = (rem_in >= shifted);
    assign rem_nxt = take ? (rem_in - shifted) : rem_in;
    assign quo_nxt = {quo_in[tfc_pkg::DUTY_W-2:0], take};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[N-1];

endmodule

FILE: design/temperature_fan_curve.sv
// temperature fan curve: adc scans in, fan duties and temperatures out
// depends on tfc_pkg and tfc_div
// an accepted beat passes the front stages, 12 divider stages and the out_tdata register
// throughput: one scan per cycle unless stalled; divider gives one quotient bit per stage
// the whole pipeline moves together and holds while the output beat is not taken
// reset (rst_n low, synchronous) empties the pipeline and loads start 4000, full 6000
module temperature_fan_curve (
  input  logic                              clk,
  input  logic                              rst_n,
  // sensor0_raw [11:0], sensor1_raw [23:12], sensor2_raw [35:24], sensor3_raw [47:36]
  input  logic [tfc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fan0_duty [11:0], fan1_duty [23:12], sensor0_temp [39:24], sensor1_temp [55:40],
  // sensor2_temp [71:56], sensor3_temp [87:72]
  output logic [tfc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  tfc_pkg::cfg_idx_t                 cfg_index,
  input  tfc_pkg::temp_t                    cfg_data
);

  localparam int unsigned NS = tfc_pkg::SENSORS;
  localparam int unsigned ND = tfc_pkg::DIV_STEPS;

  // ---------------------------------------------------------------
  // configuration registers, always writable
  // ---------------------------------------------------------------
  tfc_pkg::temp_t start_r [NS];
  tfc_pkg::temp_t full_r  [NS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        start_r[i] <= tfc_pkg::START_RESET;
        full_r[i]  <= tfc_pkg::FULL_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      // low half of the map holds start thresholds, upper half full thresholds
      if (cfg_index < tfc_pkg::CFG_FULL_BASE) begin
        start_r[cfg_index[1:0]] <= cfg_data;
      end else begin
        full_r[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------
  // global advance: the pipeline moves whenever the output slot frees up
  // ---------------------------------------------------------------
  logic out_tvalid_r;
  logic en;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // stage 1: raw * 33000
  logic           v1_r;
  tfc_pkg::prod_t x1_r [NS];
  // stage 2: reciprocal estimate of x / 4095 (x * 4097 >> 24), low by at most one
  logic           v2_r;
  tfc_pkg::prod_t x2_r [NS];
  tfc_pkg::temp_t q2_r [NS];
  // stage 3: remainder check fixes the estimate, temperature final
  logic           v3_r;
  tfc_pkg::temp_t temp3_r [NS];
  // stage 4: ramp flags, numerator (t - start) * 4095 and divisor full - start
  logic           v4_r;
  tfc_pkg::temp_t temp4_r [NS];
  logic [NS-1:0]  low4_r;
  logic [NS-1:0]  high4_r;
  tfc_pkg::prod_t num4_r [NS];
  tfc_pkg::temp_t den4_r [NS];
  // side data riding along the divider stages
  logic [ND-1:0]  vd_r;
  tfc_pkg::temp_t tempd_r [ND][NS];
  logic [NS-1:0]  lowd_r  [ND];
  logic [NS-1:0]  highd_r [ND];

  tfc_pkg::duty_t quo [NS];

  // combinational next values per stage
  tfc_pkg::prod_t x1_nxt   [NS];
  tfc_pkg::temp_t q2_nxt   [NS];
  tfc_pkg::temp_t temp3_nxt[NS];
  logic [NS-1:0]  low4_nxt;
  logic [NS-1:0]  high4_nxt;
  tfc_pkg::prod_t num4_nxt [NS];
  tfc_pkg::temp_t den4_nxt [NS];

  always_comb begin
    logic [39:0]    scaled;
    logic [28:0]    rem_wide;
    logic [12:0]    rem;
    tfc_pkg::temp_t diff;
    for (int i = 0; i < NS; i++) begin
      // code to centidegrees, product fits 28 bits
      x1_nxt[i] = tfc_pkg::prod_t'(in_tdata[i*tfc_pkg::RAW_W +: tfc_pkg::RAW_W])
                * tfc_pkg::prod_t'(tfc_pkg::TEMP_SCALE);

      // x * 4097 as a shift and add
      scaled    = {12'b0, x1_r[i]} + {x1_r[i], 12'b0};
      q2_nxt[i] = scaled[39:24];

      // remainder x - q * 4095 stays below 2 * 4095
      rem_wide     = 29'(x2_r[i]) + 29'(q2_r[i]) - (29'(q2_r[i]) << 12);
      rem          = rem_wide[12:0];
      temp3_nxt[i] = q2_r[i] + tfc_pkg::temp_t'(rem >= tfc_pkg::ADC_DIV);

      // at or below start gives zero, at or above full gives full duty
      low4_nxt[i]  = (temp3_r[i] <= start_r[i]);
      high4_nxt[i] = (temp3_r[i] >= full_r[i]);
      diff         = temp3_r[i] - start_r[i];
      num4_nxt[i]  = (tfc_pkg::prod_t'(diff) << 12) - tfc_pkg::prod_t'(diff);
      den4_nxt[i]  = full_r[i] - start_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      vd_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      vd_r         <= {vd_r[ND-2:0], v4_r};
      out_tvalid_r <= vd_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        x1_r[i]    <= x1_nxt[i];
        x2_r[i]    <= x1_r[i];
        q2_r[i]    <= q2_nxt[i];
        temp3_r[i] <= temp3_nxt[i];
        temp4_r[i] <= temp3_r[i];
        num4_r[i]  <= num4_nxt[i];
        den4_r[i]  <= den4_nxt[i];
      end
      low4_r  <= low4_nxt;
      high4_r <= high4_nxt;
      tempd_r[0] <= temp4_r;
      lowd_r[0]  <= low4_r;
      highd_r[0] <= high4_r;
      for (int s = 1; s < ND; s++) begin
        tempd_r[s] <= tempd_r[s-1];
        lowd_r[s]  <= lowd_r[s-1];
        highd_r[s] <= highd_r[s-1];
      end
    end
  end

  // one pipelined divider per sensor lane
  for (genvar i = 0; i < NS; i++) begin : g_lane
    tfc_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (num4_r[i]),
      .den_i (den4_r[i]),
      .quo_o (quo[i])
    );
  end

  // ---------------------------------------------------------------
  // output stage: pick ramp value per sensor, max per fan
  // ---------------------------------------------------------------
  tfc_pkg::duty_t ramp [NS];
  tfc_pkg::duty_t duty0_nxt;
  tfc_pkg::duty_t duty1_nxt;
  logic [tfc_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [tfc_pkg::OUT_DATA_W-1:0] out_tdata_nxt;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (lowd_r[ND-1][i]) begin
        ramp[i] = '0;
      end else if (highd_r[ND-1][i]) begin
        ramp[i] = tfc_pkg::DUTY_MAX;
      end else begin
        ramp[i] = quo[i];
      end
    end
    duty0_nxt = (ramp[0] > ramp[1]) ? ramp[0] : ramp[1];
    duty1_nxt = (ramp[2] > ramp[3]) ? ramp[2] : ramp[3];
    out_tdata_nxt = {tempd_r[ND-1][3], tempd_r[ND-1][2], tempd_r[ND-1][1],
                     tempd_r[ND-1][0], duty1_nxt, duty0_nxt};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

`ifndef ASSERT_OFF
  // the first stage fills only from an accepted input beat
  a_fill_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v1_r) |-> $past(in_tvalid && in_tready))
    else $error("stage 1 filled without an accepted beat");

  // a stalled pipeline keeps every valid bit in place
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v1_r, v2_r, v3_r, v4_r, vd_r, out_tvalid_r}))
    else $error("valid bits moved during a stall");

  // converted temperatures never exceed full scale
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (temp3_r[0] <= tfc_pkg::TEMP_SCALE) && (temp3_r[1] <= tfc_pkg::TEMP_SCALE)
          && (temp3_r[2] <= tfc_pkg::TEMP_SCALE) && (temp3_r[3] <= tfc_pkg::TEMP_SCALE))
    else $error("temperature above full scale");

  // inside the ramp the lane 0 quotient stays below full duty
  a_ramp_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (vd_r[ND-1] && !lowd_r[ND-1][0] && !highd_r[ND-1][0]) |-> (quo[0] != tfc_pkg::DUTY_MAX))
    else $error("ramp quotient reached full duty");

  // a write to full threshold 0 lands in its register
  a_cfg_full_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == tfc_pkg::CFG_FULL_BASE)
      |=> (full_r[0] == $past(cfg_data)))
    else $error("full threshold write lost");
`endif

endmodule

FILE: tb/tb_temperature_fan_curve.sv
// self-checking bench for temperature_fan_curve: adc scans in, duties and temperatures out
// holds its own threshold copy and ramp predictor in a small scoreboard class
// depends on tfc_pkg and the temperature_fan_curve rtl
module tb_temperature_fan_curve;
  timeunit 1ns;
  timeprecision 1ps;

  // expected content of one result beat
  typedef struct {
    tfc_pkg::duty_t fan_duty[2];
    tfc_pkg::temp_t sensor_temp[tfc_pkg::SENSORS];
  } fan_result_t;

  // threshold copy, duty predictor and queue of pending results
  class fan_curve_scoreboard;
    tfc_pkg::temp_t start_thr[tfc_pkg::SENSORS];
    tfc_pkg::temp_t full_thr[tfc_pkg::SENSORS];
    fan_result_t    pending_q[$];
    int             errors;
    int             beat_no;

    function new();
      for (int i = 0; i < tfc_pkg::SENSORS; i++) begin
        start_thr[i] = tfc_pkg::START_RESET;
        full_thr[i]  = tfc_pkg::FULL_RESET;
      end
      errors  = 0;
      beat_no = 0;
    endfunction

    function void set_threshold(tfc_pkg::cfg_idx_t idx, tfc_pkg::temp_t v);
      if (idx < tfc_pkg::CFG_FULL_BASE) begin
        start_thr[idx - tfc_pkg::CFG_START_BASE] = v;
      end else begin
        full_thr[idx - tfc_pkg::CFG_FULL_BASE] = v;
      end
    endfunction

    // floor(raw * 33000 / 4095), exact in 32 bits
    function int unsigned centideg(tfc_pkg::raw_t raw);
      return (32'(raw) * 32'(tfc_pkg::TEMP_SCALE)) / 32'(tfc_pkg::ADC_DIV);
    endfunction

    // linear ramp; the divide only happens strictly inside (lo, hi)
    function tfc_pkg::duty_t ramp_duty(int unsigned t, int unsigned lo, int unsigned hi);
      if (t <= lo) return '0;
      if (t >= hi) return tfc_pkg::DUTY_MAX;
      return tfc_pkg::duty_t'(((t - lo) * 32'(tfc_pkg::DUTY_MAX)) / (hi - lo));
    endfunction

    function void note_scan(logic [tfc_pkg::IN_DATA_W-1:0] d);
      fan_result_t    r;
      tfc_pkg::duty_t ramp[tfc_pkg::SENSORS];
      int unsigned    t;
      for (int i = 0; i < tfc_pkg::SENSORS; i++) begin
        t = centideg(d[i*tfc_pkg::RAW_W +: tfc_pkg::RAW_W]);
        r.sensor_temp[i] = tfc_pkg::temp_t'(t);
        ramp[i] = ramp_duty(t, start_thr[i], full_thr[i]);
      end
      r.fan_duty[0] = (ramp[0] > ramp[1]) ? ramp[0] : ramp[1];
      r.fan_duty[1] = (ramp[2] > ramp[3]) ? ramp[2] : ramp[3];
      pending_q.push_back(r);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("beat %0d %s: got %0d expected %0d", beat_no, what, got, want);
      errors++;
    endtask

    task check_result(logic [tfc_pkg::OUT_DATA_W-1:0] d);
      fan_result_t want;
      beat_no++;
      if (pending_q.size() == 0) begin
        report("result with nothing pending", d[15:0], 16'd0);
        return;
      end
      want = pending_q.pop_front();
      for (int k = 0; k < 2; k++) begin
        if (d[k*tfc_pkg::DUTY_W +: tfc_pkg::DUTY_W] !== want.fan_duty[k])
          report($sformatf("fan%0d_duty", k),
                 16'(d[k*tfc_pkg::DUTY_W +: tfc_pkg::DUTY_W]), 16'(want.fan_duty[k]));
      end
      for (int i = 0; i < tfc_pkg::SENSORS; i++) begin
        if (d[2*tfc_pkg::DUTY_W + i*tfc_pkg::TEMP_W +: tfc_pkg::TEMP_W]
            !== want.sensor_temp[i])
          report($sformatf("sensor%0d_temp", i),
                 d[2*tfc_pkg::DUTY_W + i*tfc_pkg::TEMP_W +: tfc_pkg::TEMP_W],
                 want.sensor_temp[i]);
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [tfc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [tfc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  tfc_pkg::cfg_idx_t              cfg_index = '0;
  tfc_pkg::temp_t                 cfg_data = '0;

  // set by the stimulus, picked up and cleared by the receiver
  logic                           hold_req = 1'b0;

  fan_curve_scoreboard            sb;

  temperature_fan_curve uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("[temperature_fan_curve] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------

  function automatic logic [tfc_pkg::IN_DATA_W-1:0] pack_scan(int r0, int r1, int r2, int r3);
    return {tfc_pkg::raw_t'(r3), tfc_pkg::raw_t'(r2), tfc_pkg::raw_t'(r1),
            tfc_pkg::raw_t'(r0)};
  endfunction

  // offer one scan and hold it until taken; valid is left high for the next beat
  task automatic drive_scan(input logic [tfc_pkg::IN_DATA_W-1:0] d);
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_scan(d);
  endtask

  task automatic sender_gap(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender quiet until every pending result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // all eight thresholds, back to back; valid drops once after the last beat
  task automatic load_thresholds(input tfc_pkg::temp_t st[tfc_pkg::SENSORS],
                                 input tfc_pkg::temp_t fl[tfc_pkg::SENSORS]);
    for (int i = 0; i < 2 * tfc_pkg::SENSORS; i++) begin
      cfg_index <= tfc_pkg::cfg_idx_t'(i);
      cfg_data  <= (i < tfc_pkg::SENSORS) ? st[i] : fl[i - tfc_pkg::SENSORS];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.set_threshold(tfc_pkg::cfg_idx_t'(i),
                       (i < tfc_pkg::SENSORS) ? st[i] : fl[i - tfc_pkg::SENSORS]);
    end
    cfg_valid <= 1'b0;
  endtask

  // raw code biased toward the rails
  function automatic int rand_raw();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // mostly ordered ramps inside the sensor range, some steep, some arbitrary words
  task automatic pick_thresholds(output tfc_pkg::temp_t st[tfc_pkg::SENSORS],
                                 output tfc_pkg::temp_t fl[tfc_pkg::SENSORS],
                                 input bit wild);
    int lo;
    for (int i = 0; i < tfc_pkg::SENSORS; i++) begin
      lo = $urandom_range(0, 30000);
      if (wild || $urandom_range(0, 7) == 0) begin
        st[i] = tfc_pkg::temp_t'($urandom_range(0, 65535));
        fl[i] = tfc_pkg::temp_t'($urandom_range(0, 65535));
      end else if ($urandom_range(0, 3) == 0) begin
        st[i] = tfc_pkg::temp_t'(lo);
        fl[i] = tfc_pkg::temp_t'(lo + $urandom_range(1, 50));
      end else begin
        st[i] = tfc_pkg::temp_t'(lo);
        fl[i] = tfc_pkg::temp_t'(lo + $urandom_range(1, 33000 - lo));
      end
    end
  endtask

  // random scans in bursts; optionally a long receiver hold or a mid-run drain
  task automatic random_scans(input int count, input bit with_hold, input bit mid_drain);
    int burst_left;
    burst_left = 0;
    if (with_hold) hold_req = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (mid_drain && n == count / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        // back-to-back offers while the receiver is held, so the pipe backs up
        if (!with_hold && $urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 8));
      end
      burst_left--;
      drive_scan(pack_scan(rand_raw(), rand_raw(), rand_raw(), rand_raw()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: checks every accepted beat, stalls on its own pattern
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int span;
    int pct;
    hold_left = 0;
    span = 0;
    pct = 100;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      // ready rate is redrawn each time its span runs out, full rate being one option
      if (span == 0) begin
        span = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0:       pct = 100;
          1:       pct = 70;
          default: pct = 30;
        endcase
      end else begin
        span--;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    tfc_pkg::temp_t st[tfc_pkg::SENSORS];
    tfc_pkg::temp_t fl[tfc_pkg::SENSORS];
    sb = new();

    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: rails, alternating bits, codes around 40 and 60 degrees
    drive_scan(pack_scan(0, 0, 0, 0));
    drive_scan(pack_scan(4095, 4095, 4095, 4095));
    drive_scan(pack_scan('haaa, 'h555, 'haaa, 'h555));
    drive_scan(pack_scan('h555, 'haaa, 'h555, 'haaa));
    drive_scan(pack_scan(496, 497, 744, 745));
    drive_scan(pack_scan(620, 0, 0, 620));
    drain();

    // full equal to start, full below start, start and full at the word top,
    // start at zero with full stretched past the sensor range
    st = '{tfc_pkg::temp_t'(sb.centideg(1000)), 16'd20000, 16'hffff, 16'd0};
    fl = '{tfc_pkg::temp_t'(sb.centideg(1000)), 16'd1000, 16'hffff, 16'hffff};
    load_thresholds(st, fl);
    drive_scan(pack_scan(1000, 2481, 4095, 0));
    drive_scan(pack_scan(1001, 2482, 0, 4095));
    drive_scan(pack_scan(999, 0, 2048, 1));
    drain();

    // temperature landing exactly on start and on full of a normal ramp,
    // range ends 0 and 33000 as thresholds
    st = '{tfc_pkg::temp_t'(sb.centideg(2000)), tfc_pkg::temp_t'(sb.centideg(100)),
           16'd0, 16'd33000};
    fl = '{tfc_pkg::temp_t'(sb.centideg(3000)), tfc_pkg::temp_t'(sb.centideg(4000)),
           16'd33000, 16'd33000};
    load_thresholds(st, fl);
    drive_scan(pack_scan(2000, 100, 0, 4095));
    drive_scan(pack_scan(3000, 4000, 4095, 4094));
    drive_scan(pack_scan(2500, 4095, 1, 1));
    drain();

    // random phases, each under fresh thresholds
    for (int p = 0; p < 6; p++) begin
      pick_thresholds(st, fl, p == 4);
      load_thresholds(st, fl);
      random_scans(170, p == 1, p == 2);
      drain();
    end

    // tail: room for a stray beat to show up
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never delivered", 16'(sb.pending()), 16'd0);

    if (sb.errors == 0) begin
      $display("[temperature_fan_curve] OK");
    end else begin
      $display("[temperature_fan_curve] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tfc_pkg.sv
design/tfc_div.sv
design/temperature_fan_curve.sv
tb/tb_temperature_fan_curve.sv
